>>> src/vqd_pkg.sv
// Shared types, constants and sizes for the vertex quantize and dedup block.
package vqd_pkg;

	localparam int MAX_VERTICES = 4096;
	localparam int TABLE_SLOTS  = 8192;

	localparam int ADDR_W  = $clog2(TABLE_SLOTS);
	localparam int PROBE_W = ADDR_W + 1;
	localparam int CNT_W   = 13;
	localparam int IDX_W   = 12;
	localparam int PACK_W  = 27;
	localparam int TEX_W   = 32;
	localparam int KEY_W   = PACK_W + TEX_W;
	localparam int SLOT_W  = 1 + KEY_W + IDX_W;

	// Only the product bits up to the top of the slot field matter.
	localparam int HASH_W  = 32 + ADDR_W;
	localparam int CHUNK_W = 15;
	localparam int N_CHUNK = (HASH_W + CHUNK_W - 1) / CHUNK_W;
	localparam int KEXT_W  = N_CHUNK * CHUNK_W;
	localparam int STEP_W  = $clog2(N_CHUNK + 1);

	localparam logic [63:0] HASH_MUL = 64'h9E3779B97F4A7C15;

	localparam logic [2:0] AX_PX = 3'd0;
	localparam logic [2:0] AX_NX = 3'd1;
	localparam logic [2:0] AX_PY = 3'd2;
	localparam logic [2:0] AX_NY = 3'd3;
	localparam logic [2:0] AX_PZ = 3'd4;
	localparam logic [2:0] AX_NZ = 3'd5;

	typedef enum logic [2:0] {
		ST_OK          = 3'd0,
		ST_MISSING     = 3'd1,
		ST_RANGE       = 3'd2,
		ST_ZERO_NORMAL = 3'd3,
		ST_FULL        = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_QUANT,
		S_HASH,
		S_READ,
		S_PROBE,
		S_DONE
	} fsm_t;

	typedef struct packed {
		logic               start_of_mesh;
		logic signed [15:0] pos_x;
		logic signed [15:0] pos_y;
		logic signed [15:0] pos_z;
		logic signed [15:0] norm_x;
		logic signed [15:0] norm_y;
		logic signed [15:0] norm_z;
		logic [31:0]        tex_bits;
		logic [2:0]         attr_present;
	} corner_t;

	typedef struct packed {
		logic [IDX_W-1:0]  vertex_index;
		logic              is_new;
		logic [PACK_W-1:0] packed_vertex;
		logic [TEX_W-1:0]  tex_out;
		status_t           status;
		logic [CNT_W-1:0]  unique_count;
	} result_t;

	typedef struct packed {
		status_t           status;
		logic [PACK_W-1:0] packed_vertex;
	} quant_t;

endpackage

>>> src/vertex_quantize_dedup.sv
// Vertex quantize and dedup top level: sequencer, hash unit and probe loop.
// Each corner is taken, then quantized, then hashed (a 15-bit by HASH_W-bit
// multiplier, used once per key chunk, plus adds), then probed slot by slot
// through the registered read of the slot RAM, and last handed off. Errored
// corners skip the hash and probe. The hand-off waits while the previous
// result is stalled. After reset, and on a start of mesh once anything was
// stored, the block sweeps all TABLE_SLOTS entries to clear the valid bits
// and takes no corner meanwhile.
module vertex_quantize_dedup (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             corner_valid,
	output logic             corner_stall,
	input  vqd_pkg::corner_t corner,
	output logic             result_valid,
	input  logic             result_stall,
	output vqd_pkg::result_t result
);

	vqd_pkg::fsm_t   state_q, state_d;
	vqd_pkg::corner_t item_q;
	vqd_pkg::quant_t qres;
	vqd_pkg::status_t status_q;
	vqd_pkg::result_t out_q;

	logic [vqd_pkg::PACK_W-1:0]  packed_q;
	logic [vqd_pkg::KEY_W-1:0]   key_q;
	logic [vqd_pkg::KEXT_W-1:0]  key_ext;
	logic [vqd_pkg::STEP_W-1:0]  step_q;
	logic [vqd_pkg::STEP_W-1:0]  chunk_sel;
	logic [vqd_pkg::CHUNK_W-1:0] chunk;
	logic [vqd_pkg::CHUNK_W+vqd_pkg::HASH_W-1:0] mult_full;
	logic [vqd_pkg::HASH_W-1:0]  prod_d, prod_q, acc_q, acc_sum;
	logic [vqd_pkg::ADDR_W-1:0]  addr_q, clr_q;
	logic [vqd_pkg::PROBE_W-1:0] probes_q;
	logic [vqd_pkg::CNT_W-1:0]   count_q;
	logic [vqd_pkg::IDX_W-1:0]   idx_q;
	logic                        new_q, dirty_q, pend_q, out_valid_q;
	logic                        take, out_free;

	logic                        we;
	logic [vqd_pkg::ADDR_W-1:0]  waddr;
	logic [vqd_pkg::SLOT_W-1:0]  wdata, rdata;
	logic                        slot_vld, slot_hit, ins_we, at_limit;

	vqd_quant u_quant (
		.item (item_q),
		.res  (qres)
	);

	vqd_ram #(
		.WIDTH (vqd_pkg::SLOT_W),
		.DEPTH (vqd_pkg::TABLE_SLOTS)
	) u_slots (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (addr_q),
		.rdata (rdata)
	);

	// slot word: valid, key, index
	assign slot_vld = rdata[vqd_pkg::SLOT_W-1];
	assign slot_hit = slot_vld &&
		(rdata[vqd_pkg::IDX_W +: vqd_pkg::KEY_W] == key_q);
	assign at_limit = (count_q >= vqd_pkg::CNT_W'(vqd_pkg::MAX_VERTICES));
	assign ins_we   = (state_q == vqd_pkg::S_PROBE) && !slot_vld && !at_limit;

	assign key_ext   = vqd_pkg::KEXT_W'(key_q);
	assign chunk_sel = (step_q < vqd_pkg::STEP_W'(vqd_pkg::N_CHUNK)) ? step_q : '0;
	assign chunk     = key_ext[chunk_sel * vqd_pkg::CHUNK_W +: vqd_pkg::CHUNK_W];
	assign mult_full = chunk * vqd_pkg::HASH_MUL[vqd_pkg::HASH_W-1:0];
	assign prod_d    = vqd_pkg::HASH_W'(mult_full << (chunk_sel * vqd_pkg::CHUNK_W));
	assign acc_sum   = acc_q + prod_q;

	assign take     = corner_valid && !corner_stall;
	assign out_free = !out_valid_q || !result_stall;

	assign corner_stall = (state_q != vqd_pkg::S_IDLE);
	assign result_valid = out_valid_q;
	assign result       = out_q;

	always_comb begin
		state_d = state_q;
		we      = 1'b0;
		waddr   = addr_q;
		wdata   = {1'b1, key_q, count_q[vqd_pkg::IDX_W-1:0]};
		case (state_q)
			vqd_pkg::S_CLEAR: begin
				we    = 1'b1;
				waddr = clr_q;
				wdata = '0;
				if (clr_q == '1) begin
					state_d = pend_q ? vqd_pkg::S_QUANT : vqd_pkg::S_IDLE;
				end
			end
			vqd_pkg::S_IDLE: begin
				if (take) begin
					state_d = (corner.start_of_mesh && dirty_q) ?
						vqd_pkg::S_CLEAR : vqd_pkg::S_QUANT;
				end
			end
			vqd_pkg::S_QUANT: begin
				state_d = (qres.status == vqd_pkg::ST_OK) ?
					vqd_pkg::S_HASH : vqd_pkg::S_DONE;
			end
			vqd_pkg::S_HASH: begin
				if (step_q == vqd_pkg::STEP_W'(vqd_pkg::N_CHUNK)) begin
					state_d = vqd_pkg::S_READ;
				end
			end
			vqd_pkg::S_READ: begin
				state_d = vqd_pkg::S_PROBE;
			end
			vqd_pkg::S_PROBE: begin
				we = ins_we;
				if (!slot_vld || slot_hit ||
					probes_q == vqd_pkg::PROBE_W'(vqd_pkg::TABLE_SLOTS - 1)) begin
					state_d = vqd_pkg::S_DONE;
				end else begin
					state_d = vqd_pkg::S_READ;
				end
			end
			vqd_pkg::S_DONE: begin
				if (out_free) begin
					state_d = vqd_pkg::S_IDLE;
				end
			end
			default: state_d = vqd_pkg::S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= vqd_pkg::S_CLEAR;
			clr_q       <= '0;
			count_q     <= '0;
			dirty_q     <= 1'b0;
			pend_q      <= 1'b0;
			out_valid_q <= 1'b0;
			step_q      <= '0;
			probes_q    <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == vqd_pkg::S_CLEAR) begin
				clr_q <= clr_q + 1'b1;
				if (clr_q == '1) begin
					dirty_q <= 1'b0;
				end
			end
			if (take) begin
				pend_q <= 1'b1;
				clr_q  <= '0;
				if (corner.start_of_mesh) begin
					count_q <= '0;
				end
			end
			if (state_q == vqd_pkg::S_QUANT) begin
				step_q   <= '0;
				probes_q <= '0;
			end
			if (state_q == vqd_pkg::S_HASH) begin
				step_q <= step_q + 1'b1;
			end
			if (state_q == vqd_pkg::S_PROBE) begin
				probes_q <= probes_q + 1'b1;
			end
			if (ins_we) begin
				count_q <= count_q + 1'b1;
				dirty_q <= 1'b1;
			end
			if (state_q == vqd_pkg::S_DONE && out_free) begin
				out_valid_q <= 1'b1;
				pend_q      <= 1'b0;
			end else if (result_valid && !result_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// datapath, no reset
	always_ff @(posedge clk) begin
		if (take) begin
			item_q <= corner;
		end
		if (state_q == vqd_pkg::S_QUANT) begin
			status_q <= qres.status;
			packed_q <= qres.packed_vertex;
			key_q    <= {item_q.tex_bits, qres.packed_vertex};
			acc_q    <= '0;
			idx_q    <= '0;
			new_q    <= 1'b0;
		end
		if (state_q == vqd_pkg::S_HASH) begin
			prod_q <= prod_d;
			if (step_q != '0) begin
				acc_q <= acc_sum;
			end
			if (step_q == vqd_pkg::STEP_W'(vqd_pkg::N_CHUNK)) begin
				addr_q <= acc_sum[vqd_pkg::HASH_W-1:32];
			end
		end
		if (state_q == vqd_pkg::S_PROBE) begin
			addr_q <= addr_q + 1'b1;
			if (slot_hit) begin
				idx_q <= rdata[vqd_pkg::IDX_W-1:0];
			end else if (!slot_vld && !at_limit) begin
				idx_q <= count_q[vqd_pkg::IDX_W-1:0];
				new_q <= 1'b1;
			end else if (!slot_vld ||
				probes_q == vqd_pkg::PROBE_W'(vqd_pkg::TABLE_SLOTS - 1)) begin
				status_q <= vqd_pkg::ST_FULL;
			end
		end
		if (state_q == vqd_pkg::S_DONE && out_free) begin
			out_q.vertex_index  <= idx_q;
			out_q.is_new        <= new_q;
			out_q.packed_vertex <= packed_q;
			out_q.tex_out       <= (status_q == vqd_pkg::ST_OK ||
				status_q == vqd_pkg::ST_FULL) ? item_q.tex_bits : '0;
			out_q.status        <= status_q;
			out_q.unique_count  <= count_q;
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= vqd_pkg::CNT_W'(vqd_pkg::MAX_VERTICES))
		else $error("vertex counter past limit");

	a_insert_room: assert property (@(posedge clk) disable iff (!arst_n)
		ins_we |-> !at_limit && !slot_vld)
		else $error("insert without room");

	a_mesh_reset: assert property (@(posedge clk) disable iff (!arst_n)
		take && corner.start_of_mesh |=> count_q == '0)
		else $error("start of mesh did not clear counter");

	a_probe_bound: assert property (@(posedge clk) disable iff (!arst_n)
		probes_q <= vqd_pkg::PROBE_W'(vqd_pkg::TABLE_SLOTS))
		else $error("probe count past table size");

endmodule

>>> src/vqd_ram.sv
// Generic simple dual-port RAM with registered read.
module vqd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> src/vqd_quant.sv
// Position scaling, range check, normal axis code and packing of one corner.
module vqd_quant (
	input  vqd_pkg::corner_t item,
	output vqd_pkg::quant_t  res
);

	logic signed [19:0] t  [3];
	logic        [19:0] mg [3];
	logic        [2:0]  pos_ok;
	logic        [7:0]  sm [3];
	logic signed [15:0] p  [3];
	logic               nzx, nzy, nzz;
	logic        [2:0]  code;
	logic               zero_n;

	always_comb begin
		p[0] = item.pos_x;
		p[1] = item.pos_y;
		p[2] = item.pos_z;
		for (int i = 0; i < 3; i++) begin
			// times ten as 8x + 2x
			t[i] = (20'(p[i]) <<< 3) + (20'(p[i]) <<< 1);
			mg[i] = t[i][19] ? 20'(-t[i]) : 20'(t[i]);
			pos_ok[i] = (mg[i][19:15] == 5'd0);
			sm[i] = {t[i][19] && (mg[i][14:8] != 7'd0), mg[i][14:8]};
		end

		nzx = (item.norm_x >= 16'sd256) || (item.norm_x <= -16'sd256);
		nzy = (item.norm_y >= 16'sd256) || (item.norm_y <= -16'sd256);
		nzz = (item.norm_z >= 16'sd256) || (item.norm_z <= -16'sd256);
		zero_n = 1'b0;
		if (nzx) begin
			code = item.norm_x[15] ? vqd_pkg::AX_NX : vqd_pkg::AX_PX;
		end else if (nzy) begin
			code = item.norm_y[15] ? vqd_pkg::AX_NY : vqd_pkg::AX_PY;
		end else if (nzz) begin
			code = item.norm_z[15] ? vqd_pkg::AX_NZ : vqd_pkg::AX_PZ;
		end else begin
			code = vqd_pkg::AX_PX;
			zero_n = 1'b1;
		end

		res.packed_vertex = '0;
		if (item.attr_present != 3'b111) begin
			res.status = vqd_pkg::ST_MISSING;
		end else if (pos_ok != 3'b111) begin
			res.status = vqd_pkg::ST_RANGE;
		end else if (zero_n) begin
			res.status = vqd_pkg::ST_ZERO_NORMAL;
		end else begin
			res.status = vqd_pkg::ST_OK;
			res.packed_vertex = {code, sm[2], sm[1], sm[0]};
		end
	end

endmodule

>>> verif/vertex_quantize_dedup_tb.sv
// Self-checking testbench for the vertex quantize and dedup block.
`timescale 1ns / 1ps

module vertex_quantize_dedup_tb;

	localparam int CYCLE_LIMIT = 3000000;

	// Predicts the result of each corner from its own copy of the table.
	class dedup_scoreboard;
		logic [vqd_pkg::KEY_W-1:0] slot_key [vqd_pkg::TABLE_SLOTS];
		bit                        slot_used [vqd_pkg::TABLE_SLOTS];
		logic [vqd_pkg::IDX_W-1:0] slot_idx [vqd_pkg::TABLE_SLOTS];
		int unsigned               vertex_count;
		vqd_pkg::result_t          pending [$];
		int                        errors;

		function void clear_mesh();
			foreach (slot_used[i]) slot_used[i] = 0;
			vertex_count = 0;
		endfunction

		function int scaled_pos(logic signed [15:0] q);
			int t;
			t = int'(q) * 10;
			if (t < 0) return -((-t) >>> 8);
			return t >>> 8;
		endfunction

		function logic [7:0] sign_mag(int v);
			int m;
			m = v < 0 ? -v : v;
			return {v < 0 ? 1'b1 : 1'b0, m[6:0]};
		endfunction

		function bit nonzero_int(logic signed [15:0] q);
			int m;
			m = int'(q);
			if (m < 0) m = -m;
			return (m >> 8) != 0;
		endfunction

		function int unsigned home_slot(logic [vqd_pkg::KEY_W-1:0] key);
			logic [63:0] h;
			h = 64'(key) * vqd_pkg::HASH_MUL;
			return 32'(h[32 +: vqd_pkg::ADDR_W]);
		endfunction

		function void note_corner(vqd_pkg::corner_t c);
			vqd_pkg::result_t r;
			int px, py, pz;
			logic [2:0] axis;
			bit have_axis;
			logic [vqd_pkg::KEY_W-1:0] key;
			int unsigned s, n, free_s;
			bit found, have_free;

			if (c.start_of_mesh) clear_mesh();
			r = '0;
			r.status = vqd_pkg::ST_OK;
			px = scaled_pos(c.pos_x);
			py = scaled_pos(c.pos_y);
			pz = scaled_pos(c.pos_z);
			have_axis = 1;
			if (nonzero_int(c.norm_x))
				axis = c.norm_x > 16'sd0 ? vqd_pkg::AX_PX : vqd_pkg::AX_NX;
			else if (nonzero_int(c.norm_y))
				axis = c.norm_y > 16'sd0 ? vqd_pkg::AX_PY : vqd_pkg::AX_NY;
			else if (nonzero_int(c.norm_z))
				axis = c.norm_z > 16'sd0 ? vqd_pkg::AX_PZ : vqd_pkg::AX_NZ;
			else have_axis = 0;

			if (c.attr_present != 3'b111) r.status = vqd_pkg::ST_MISSING;
			else if (px < -127 || px > 127 || py < -127 || py > 127 ||
					pz < -127 || pz > 127) r.status = vqd_pkg::ST_RANGE;
			else if (!have_axis) r.status = vqd_pkg::ST_ZERO_NORMAL;
			else begin
				r.packed_vertex = {axis, sign_mag(pz), sign_mag(py), sign_mag(px)};
				r.tex_out = c.tex_bits;
				key = {c.tex_bits, r.packed_vertex};
				s = home_slot(key);
				found = 0;
				have_free = 0;
				free_s = 0;
				for (n = 0; n < vqd_pkg::TABLE_SLOTS; n++) begin
					if (!slot_used[s]) begin
						have_free = 1;
						free_s = s;
						break;
					end
					if (slot_key[s] == key) begin
						found = 1;
						r.vertex_index = slot_idx[s];
						break;
					end
					s = (s + 1) % vqd_pkg::TABLE_SLOTS;
				end
				if (!found) begin
					if (!have_free || vertex_count >= vqd_pkg::MAX_VERTICES)
						r.status = vqd_pkg::ST_FULL;
					else begin
						r.vertex_index = vertex_count[vqd_pkg::IDX_W-1:0];
						slot_used[free_s] = 1;
						slot_key[free_s] = key;
						slot_idx[free_s] = vertex_count[vqd_pkg::IDX_W-1:0];
						vertex_count++;
						r.is_new = 1;
					end
				end
			end
			r.unique_count = vertex_count[vqd_pkg::CNT_W-1:0];
			pending.push_back(r);
		endfunction

		function void check_result(vqd_pkg::result_t got);
			vqd_pkg::result_t w;
			if (pending.size() == 0) begin
				$display("%0t: unexpected result %p", $time, got);
				errors++;
				return;
			end
			w = pending.pop_front();
			if (got.vertex_index !== w.vertex_index) begin
				$display("%0t: vertex_index exp %0d got %0d", $time, w.vertex_index,
					got.vertex_index);
				errors++;
			end
			if (got.is_new !== w.is_new) begin
				$display("%0t: is_new exp %0d got %0d", $time, w.is_new, got.is_new);
				errors++;
			end
			if (got.packed_vertex !== w.packed_vertex) begin
				$display("%0t: packed_vertex exp %h got %h", $time, w.packed_vertex,
					got.packed_vertex);
				errors++;
			end
			if (got.tex_out !== w.tex_out) begin
				$display("%0t: tex_out exp %h got %h", $time, w.tex_out, got.tex_out);
				errors++;
			end
			if (got.status !== w.status) begin
				$display("%0t: status exp %0d got %0d", $time, w.status, got.status);
				errors++;
			end
			if (got.unique_count !== w.unique_count) begin
				$display("%0t: unique_count exp %0d got %0d", $time, w.unique_count,
					got.unique_count);
				errors++;
			end
		endfunction
	endclass

	logic             clk = 0;
	logic             arst_n = 0;
	logic             corner_valid = 0;
	logic             corner_stall;
	vqd_pkg::corner_t corner = '0;
	logic             result_valid;
	logic             result_stall = 1;
	vqd_pkg::result_t result;

	dedup_scoreboard  board = new();
	int               cycles = 0;
	int               stall_mode = 0;
	int               hold_left = 0;
	vqd_pkg::corner_t recent [$];

	vertex_quantize_dedup i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.corner_valid(corner_valid),
		.corner_stall(corner_stall),
		.corner(corner),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// Check results; hold each waiting result for a drawn number of cycles.
	always @(posedge clk) begin
		if (arst_n) begin
			if (result_valid && !result_stall) begin
				board.check_result(result);
				hold_left = $urandom_range(0, stall_mode);
			end else if (result_valid && hold_left > 0) begin
				hold_left = hold_left - 1;
			end
			result_stall <= (hold_left > 0);
		end
	end

	task automatic send_corner(vqd_pkg::corner_t c);
		int gap;
		gap = $urandom_range(0, 14);
		if ($urandom_range(0, 3) == 0) gap = 0;
		if (gap != 0) begin
			corner_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		corner_valid <= 1'b1;
		corner <= c;
		@(posedge clk);
		while (corner_stall) @(posedge clk);
		board.note_corner(c);
		recent.push_back(c);
		if (recent.size() > 64) void'(recent.pop_front());
	endtask

	function automatic logic [15:0] rand_pos();
		// Mostly in range: |q| < 3277 keeps the scaled value within 127.
		case ($urandom_range(0, 9))
			0: return 16'($urandom);
			1: return 16'($signed($urandom_range(0, 6)) - 3);
			default: return 16'($signed($urandom_range(0, 6552)) - 3276);
		endcase
	endfunction

	function automatic logic [15:0] rand_norm();
		case ($urandom_range(0, 5))
			0: return 16'($signed($urandom_range(0, 510)) - 255);
			1: return 16'($urandom);
			default: return 16'($signed($urandom_range(0, 1024)) - 512);
		endcase
	endfunction

	function automatic vqd_pkg::corner_t make_corner(logic [15:0] px, logic [15:0] py,
			logic [15:0] pz, logic [15:0] nx, logic [15:0] ny, logic [15:0] nz,
			logic [31:0] tex, logic [2:0] attr, logic som);
		vqd_pkg::corner_t c;
		c.start_of_mesh = som;
		c.pos_x = px;
		c.pos_y = py;
		c.pos_z = pz;
		c.norm_x = nx;
		c.norm_y = ny;
		c.norm_z = nz;
		c.tex_bits = tex;
		c.attr_present = attr;
		return c;
	endfunction

	task automatic random_corner();
		vqd_pkg::corner_t c;
		int pick;
		pick = $urandom_range(0, 19);
		if (pick < 6 && recent.size() > 0) begin
			// Repeat an earlier vertex to exercise the lookup hit path.
			c = recent[$urandom_range(0, recent.size() - 1)];
			c.start_of_mesh = 1'b0;
			if ($urandom_range(0, 3) == 0)
				c.tex_bits[5'($urandom_range(0, 31))] ^= 1'b1;
		end else begin
			c = make_corner(rand_pos(), rand_pos(), rand_pos(), rand_norm(),
				rand_norm(), rand_norm(), $urandom_range(0, 1) ? $urandom :
				$urandom_range(0, 3), 3'b111, 1'b0);
			if ($urandom_range(0, 9) == 0) c.attr_present = 3'($urandom_range(0, 6));
		end
		if ($urandom_range(0, 149) == 0) c.start_of_mesh = 1'b1;
		send_corner(c);
	endtask

	task automatic wait_drained();
		while (board.pending.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	initial begin
		int i;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// Directed corners: extremes, every axis code and each quantize error.
		send_corner(make_corner('0, '0, '0, 16'sh0100, '0, '0,
			32'h0, 3'b111, 1'b1));
		send_corner(make_corner('0, '0, '0, 16'sh0100, '0, '0,
			32'h0, 3'b111, 1'b0));
		send_corner(make_corner(16'sd3276, -16'sd3276, 16'sd25, 16'shFF00, '0, '0,
			32'hFFFF_FFFF, 3'b111, 1'b0));
		send_corner(make_corner(16'sd3277, '0, '0, 16'sh0100, '0, '0, 32'h1,
			3'b111, 1'b0));
		send_corner(make_corner('0, -16'sd3277, '0, 16'sh0100, '0, '0, 32'h1,
			3'b111, 1'b0));
		send_corner(make_corner('0, '0, 16'sh7FFF, 16'sh0100, '0, '0, 32'h1,
			3'b111, 1'b0));
		send_corner(make_corner(16'sh8000, '0, '0, 16'sh0100, '0, '0, 32'h1,
			3'b111, 1'b0));
		send_corner(make_corner(16'sd26, 16'sd25, -16'sd26, 16'sh00FF, 16'sh0200, '0,
			32'h2, 3'b111, 1'b0));
		send_corner(make_corner(16'sd1, 16'sd2, 16'sd3, -16'sh00FF, 16'shFE00, '0,
			32'h2, 3'b111, 1'b0));
		send_corner(make_corner(16'sd1, 16'sd2, 16'sd3, '0, 16'sh00FF, 16'sh7FFF,
			32'h2, 3'b111, 1'b0));
		send_corner(make_corner(16'sd1, 16'sd2, 16'sd3, '0, '0, 16'sh8000,
			32'h2, 3'b111, 1'b0));
		send_corner(make_corner(16'sd1, 16'sd2, 16'sd3, 16'sh00FF, -16'sh00FF,
			16'sh00FF, 32'h2, 3'b111, 1'b0));
		send_corner(make_corner(16'sd1, 16'sd2, 16'sd3, 16'sh7FFF, '0, '0,
			32'h2, 3'b011, 1'b0));
		send_corner(make_corner(16'sd1, 16'sd2, 16'sd3, 16'sh7FFF, '0, '0,
			32'h2, 3'b101, 1'b0));
		send_corner(make_corner(16'sd1, 16'sd2, 16'sd3, 16'sh7FFF, '0, '0,
			32'h2, 3'b110, 1'b0));
		send_corner(make_corner(16'sh8000, 16'sd2, 16'sd3, '0, '0, '0,
			32'h2, 3'b000, 1'b0));
		send_corner(make_corner(16'sh7FFF, 16'sd2, 16'sd3, '0, '0, '0,
			32'h2, 3'b111, 1'b0));
		send_corner(make_corner(16'sd3276, -16'sd3276, 16'sd25, 16'shFF00, '0, '0,
			32'hFFFF_FFFF, 3'b111, 1'b0));
		send_corner(make_corner('0, '0, '0, 16'sh0100, '0, '0, 32'h0, 3'b111, 1'b1));

		// Random corners with varying result back-pressure.
		for (i = 0; i < 575; i++) begin
			if (i % 100 == 0) stall_mode = $urandom_range(0, 14);
			random_corner();
		end

		stall_mode = 3;
		send_corner(make_corner('0, '0, '0, 16'sh0100, '0, '0, 32'd9, 3'b111, 1'b1));
		corner_valid <= 1'b0;

		wait_drained();
		if (board.errors == 0 && board.pending.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

>>> sim.f
src/vqd_pkg.sv
src/vqd_ram.sv
src/vqd_quant.sv
src/vertex_quantize_dedup.sv
verif/vertex_quantize_dedup_tb.sv
